// File: rtl/rwst_pkg.sv
// Package for the raycast wall slice texturer: fixed sizes, constants and state type.
// Used by rwst_div and raycast_wall_slice_texturer_top; depends on nothing.
package rwst_pkg;

    localparam int TEX_DIM    = 64;
    localparam int SCREEN_H   = 512;
    localparam int DIV_W      = 26;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [5:0]       TEX_MAX     = 6'(TEX_DIM - 1);
    localparam logic [14:0]      HALF_SCREEN = 15'(SCREEN_H / 2);
    localparam logic [8:0]       LAST_SCREEN = 9'(SCREEN_H - 1);
    localparam logic [DIV_W-1:0] H_DIVIDEND  = DIV_W'(SCREEN_H * 65536);
    localparam logic [DIV_W-1:0] S_DIVIDEND  = DIV_W'(TEX_DIM * 65536);
    localparam logic [15:0]      HEIGHT_MAX  = 16'hFFFF;
    localparam logic [23:0]      STEP_MAX    = 24'hFFFFFF;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIST = 7'b0000010,
        ST_DIVH = 7'b0000100,
        ST_STEP = 7'b0001000,
        ST_DIVS = 7'b0010000,
        ST_MUL2 = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

endpackage

// File: rtl/rwst_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rwst_pkg for the operand width.
module rwst_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rwst_pkg::DIV_W-1:0]  dividend,
    input  logic [rwst_pkg::DIV_W-1:0]  divisor,
    output logic                        done,
    output logic [rwst_pkg::DIV_W-1:0]  quotient
);
    import rwst_pkg::*;

    logic [DIV_W-1:0]     rem_reg, quo_reg, dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DIV_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/raycast_wall_slice_texturer_top.sv
// Top level of the raycast wall slice texturer: ray setup sequencer and row stepping.
// Depends on rwst_pkg and rwst_div.
//
// A ray item (kind 0) passes through ST_DIST, ST_DIVH, ST_STEP, ST_DIVS and ST_MUL2
// before its result is offered in ST_OUT: one shared 26-bit serial divider
// computes the slice height and then the texture step, one bit per cycle, and
// one shared multiplier forms the wall hit point and the start texture position.
// A row item (kind 1) is accepted in ST_IDLE and its result is handed over in
// ST_OUT. The block takes no new item until its result has been taken. The slice
// state clears at reset, so row items before any ray give an empty range.
module raycast_wall_slice_texturer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [9:0]  column,
    input  logic        side,
    input  logic [25:0] side_dist_x,
    input  logic [25:0] side_dist_y,
    input  logic [25:0] delta_dist_x,
    input  logic [25:0] delta_dist_y,
    input  logic signed [18:0] ray_dir_x,
    input  logic signed [18:0] ray_dir_y,
    input  logic [23:0] player_x,
    input  logic [23:0] player_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        row_valid,
    output logic [9:0]  screen_x,
    output logic [8:0]  screen_y,
    output logic [8:0]  draw_end_row,
    output logic [15:0] slice_height,
    output logic [1:0]  face,
    output logic [5:0]  tex_x,
    output logic [5:0]  tex_y,
    output logic [13:0] texel_address,
    output logic        last_row
);
    import rwst_pkg::*;

    state_t state_reg;

    // Slice state.
    logic [1:0]  face_reg;
    logic [5:0]  tex_col_reg;
    logic [23:0] tex_step_reg;
    logic [31:0] tex_pos_reg;
    logic [8:0]  cur_row_reg, end_row_reg;
    logic [9:0]  cur_column_reg;

    // Captured ray item and intermediate values.
    logic [9:0]  col_reg;
    logic        side_reg;
    logic signed [18:0] dir_x_reg, dir_y_reg;
    logic [15:0] pos_frac_reg;
    logic [25:0] dist_reg;
    logic [15:0] h_reg;
    logic [8:0]  start_reg, end_reg;
    logic [14:0] off_reg;
    logic [51:0] prod_reg;

    // Output registers.
    logic        out_valid_reg, row_valid_reg, last_reg;
    logic [9:0]  sx_reg;
    logic [8:0]  sy_reg, de_reg;
    logic [15:0] sh_reg;
    logic [1:0]  face_o_reg;
    logic [5:0]  tx_o_reg, ty_o_reg;
    logic [13:0] addr_reg;

    logic [25:0] sd, dd, dist_comb;
    assign sd        = side ? side_dist_y : side_dist_x;
    assign dd        = side ? delta_dist_y : delta_dist_x;
    assign dist_comb = (sd > dd) ? 26'(sd - dd) : '0;

    // Shared divider.
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_q, div_dividend, div_divisor;
    assign div_start    = (state_reg == ST_DIST) || (state_reg == ST_STEP);
    assign div_dividend = (state_reg == ST_DIST) ? H_DIVIDEND : S_DIVIDEND;
    assign div_divisor  = (state_reg == ST_DIST) ? dist_reg : {10'd0, h_reg};

    rwst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    function automatic logic signed [24:0] ray_sext(input logic signed [18:0] d);
        ray_sext = 25'(d);
    endfunction

    // Shared multiplier: dist * ray direction, then offset * step.
    logic signed [26:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [51:0] mul_p;
    always_comb
    begin
        if (state_reg == ST_DIST)
        begin
            mul_a = $signed({1'b0, dist_reg});
            mul_b = side_reg ? 25'(ray_sext(dir_x_reg)) : 25'(ray_sext(dir_y_reg));
        end
        else
        begin
            mul_a = $signed({12'd0, off_reg});
            mul_b = $signed({1'b0, tex_step_reg});
        end
        mul_p = mul_a * mul_b;
    end

    // Height-derived values once the first division finishes.
    logic [15:0] h_sat;
    logic [14:0] half_h;
    logic        clip;
    logic [15:0] frac;
    logic [5:0]  tx_raw, tx_m;
    logic        dx_neg, dy_neg, dy_pos, dx_pos;
    logic [1:0]  face_c;
    assign h_sat  = (dist_reg == '0 || div_q > 26'(HEIGHT_MAX)) ? HEIGHT_MAX : div_q[15:0];
    assign half_h = h_sat[15:1];
    assign clip   = half_h >= HALF_SCREEN;
    assign frac   = 16'(pos_frac_reg + prod_reg[31:16]);
    assign tx_raw = frac[15:10];
    assign dx_neg = dir_x_reg[18];
    assign dy_neg = dir_y_reg[18];
    assign dx_pos = !dx_neg && (dir_x_reg != '0);
    assign dy_pos = !dy_neg && (dir_y_reg != '0);
    assign tx_m   = ((!side_reg && dx_neg) || (side_reg && dy_pos)) ? 6'(TEX_MAX - tx_raw)
                                                                     : tx_raw;
    assign face_c = side_reg ? (dy_neg ? 2'd0 : 2'd1) : (dx_pos ? 2'd2 : 2'd3);

    logic row_has;
    logic [5:0] ty_c;
    assign row_has = cur_row_reg < end_row_reg;
    assign ty_c    = tex_pos_reg[21:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            face_reg       <= '0;
            tex_col_reg    <= '0;
            tex_step_reg   <= '0;
            tex_pos_reg    <= '0;
            cur_row_reg    <= '0;
            end_row_reg    <= '0;
            cur_column_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (!kind)
                        begin
                            state_reg <= ST_DIST;
                        end
                        else
                        begin
                            if (row_has)
                            begin
                                tex_pos_reg <= tex_pos_reg + {8'd0, tex_step_reg};
                                cur_row_reg <= cur_row_reg + 1'b1;
                            end
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                    end
                end
                ST_DIST: state_reg <= ST_DIVH;
                ST_DIVH:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: state_reg <= ST_DIVS;
                ST_DIVS:
                begin
                    if (div_done)
                    begin
                        tex_step_reg <= (div_q > 26'(STEP_MAX)) ? STEP_MAX : div_q[23:0];
                        state_reg    <= ST_MUL2;
                    end
                end
                ST_MUL2:
                begin
                    tex_pos_reg    <= mul_p[31:0];
                    face_reg       <= face_o_reg;
                    tex_col_reg    <= tx_o_reg;
                    cur_row_reg    <= start_reg;
                    end_row_reg    <= end_reg;
                    cur_column_reg <= col_reg;
                    out_valid_reg  <= 1'b1;
                    state_reg      <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            if (!kind)
            begin
                col_reg      <= column;
                side_reg     <= side;
                dir_x_reg    <= ray_dir_x;
                dir_y_reg    <= ray_dir_y;
                pos_frac_reg <= side ? player_x[15:0] : player_y[15:0];
                dist_reg     <= dist_comb;
            end
            else
            begin
                row_valid_reg <= row_has;
                sx_reg        <= cur_column_reg;
                sy_reg        <= cur_row_reg;
                de_reg        <= end_row_reg;
                sh_reg        <= '0;
                face_o_reg    <= face_reg;
                tx_o_reg      <= tex_col_reg;
                ty_o_reg      <= row_has ? ty_c : '0;
                addr_reg      <= row_has ? {face_reg, ty_c, tex_col_reg} : '0;
                last_reg      <= row_has && (9'(cur_row_reg + 1'b1) == end_row_reg);
            end
        end
        if (state_reg == ST_DIST)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_DIVH && div_done)
        begin
            h_reg      <= h_sat;
            start_reg  <= clip ? 9'd0 : 9'(HALF_SCREEN - half_h);
            end_reg    <= clip ? LAST_SCREEN : 9'(HALF_SCREEN + half_h);
            off_reg    <= clip ? 15'(half_h - HALF_SCREEN) : '0;
            face_o_reg <= face_c;
            tx_o_reg   <= tx_m;
        end
        if (state_reg == ST_MUL2)
        begin
            row_valid_reg <= 1'b0;
            sx_reg        <= col_reg;
            sy_reg        <= start_reg;
            de_reg        <= end_reg;
            sh_reg        <= h_reg;
            ty_o_reg      <= '0;
            addr_reg      <= '0;
            last_reg      <= 1'b0;
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign row_valid     = row_valid_reg;
    assign screen_x      = sx_reg;
    assign screen_y      = sy_reg;
    assign draw_end_row  = de_reg;
    assign slice_height  = sh_reg;
    assign face          = face_o_reg;
    assign tex_x         = tx_o_reg;
    assign tex_y         = ty_o_reg;
    assign texel_address = addr_reg;
    assign last_row      = last_reg;

endmodule
